[rtl/oms_pkg.sv]
// oms_pkg: shared widths, constants, tables and types for the orientation median smoother
// used by oms_cordic, oms_isqrt and orientation_median_smoother; no dependencies

package oms_pkg;

  localparam int WINDOW_DEF       = 5;
  localparam int CORDIC_STEPS_DEF = 14;

  localparam int Q_W     = 16;
  localparam int ACC_W   = 36;
  localparam int A_W     = 30;
  localparam int CW      = 40;
  localparam int ZW      = 20;
  localparam int TRIG_W  = 24;
  localparam int PAIR_W  = 48;
  localparam int OACC_W  = 64;
  localparam int MUL_W   = 33;
  localparam int SQ_W    = 58;
  localparam int ROOT_W  = 29;
  localparam int ISQ_CW  = 5;
  localparam int STEP_W  = 5;
  localparam int LO_W    = 24;
  localparam int OUT_SH  = 46;

  localparam longint ONE_Q28    = 64'sd268435456;
  localparam longint HALFPI_Q16 = 64'sd102944;
  localparam longint KINV_Q28   = 64'sd163008218;
  localparam int     PI_Q13     = 25736;
  localparam int     HALFPI_Q13 = 12868;
  localparam int     TWOPI_Q13  = 51472;
  localparam int     QLIM       = 16384;

  localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << 56;

  localparam logic [STEP_W-1:0] PROD_LAST = 5'd9;
  localparam logic [STEP_W-1:0] QUAT_LAST = 5'd20;

  localparam logic [1:0] ANG_ROLL  = 2'd0;
  localparam logic [1:0] ANG_PITCH = 2'd1;
  localparam logic [1:0] ANG_YAW   = 2'd2;

  localparam logic [1:0] PR_SRCP = 2'd0;
  localparam logic [1:0] PR_CRSP = 2'd1;
  localparam logic [1:0] PR_CRCP = 2'd2;
  localparam logic [1:0] PR_SRSP = 2'd3;

  localparam logic [1:0] OQ_X = 2'd0;
  localparam logic [1:0] OQ_Y = 2'd1;
  localparam logic [1:0] OQ_Z = 2'd2;
  localparam logic [1:0] OQ_W = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SQUARE,
    ST_ROOT,
    ST_VEC,
    ST_MED,
    ST_ROT,
    ST_QUAT,
    ST_OUT
  } state_t;

  typedef enum logic {
    CM_VECTOR,
    CM_ROTATE
  } cordic_mode_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic [1:0] pair;
    logic       use_sin;
    logic [1:0] dest;
    logic       neg;
  } term_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] n);
    logic signed [ZW-1:0] v;
    unique case (n)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

  // pair product times cy or sy, summed into one quaternion component
  function automatic term_t term_of(input logic [2:0] j);
    term_t t;
    unique case (j)
      3'd0:    t = '{pair: PR_SRCP, use_sin: 1'b0, dest: OQ_X, neg: 1'b0};
      3'd1:    t = '{pair: PR_CRSP, use_sin: 1'b1, dest: OQ_X, neg: 1'b1};
      3'd2:    t = '{pair: PR_CRSP, use_sin: 1'b0, dest: OQ_Y, neg: 1'b0};
      3'd3:    t = '{pair: PR_SRCP, use_sin: 1'b1, dest: OQ_Y, neg: 1'b0};
      3'd4:    t = '{pair: PR_CRCP, use_sin: 1'b1, dest: OQ_Z, neg: 1'b0};
      3'd5:    t = '{pair: PR_SRSP, use_sin: 1'b0, dest: OQ_Z, neg: 1'b1};
      3'd6:    t = '{pair: PR_CRCP, use_sin: 1'b0, dest: OQ_W, neg: 1'b0};
      default: t = '{pair: PR_SRSP, use_sin: 1'b1, dest: OQ_W, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

[rtl/oms_cordic.sv]
// oms_cordic: iterative cordic, one micro-rotation per cycle, vectoring or rotation mode
// depends on oms_pkg (widths, atan table, control struct)

module oms_cordic #(
  parameter int STEPS = oms_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  oms_pkg::cordic_ctl_t             ctl,
  input  logic signed [oms_pkg::CW-1:0]    x_in,
  input  logic signed [oms_pkg::CW-1:0]    y_in,
  input  logic signed [oms_pkg::ZW-1:0]    z_in,
  output logic                             done,
  output logic signed [oms_pkg::CW-1:0]    x_out,
  output logic signed [oms_pkg::CW-1:0]    y_out,
  output logic signed [oms_pkg::ZW-1:0]    z_out
);

  localparam int CW = oms_pkg::CW;
  localparam int ZW = oms_pkg::ZW;
  localparam int NW = $clog2(STEPS);

  logic signed [CW-1:0] x, y, x_next, y_next, dx, dy;
  logic signed [ZW-1:0] z, z_next, at;
  logic [NW-1:0]        n;
  logic                 busy;
  logic                 plus;
  oms_pkg::cordic_mode_t mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && n == NW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode <= ctl.mode;
      n    <= '0;
      if (ctl.mode == oms_pkg::CM_ROTATE) begin
        x <= CW'(oms_pkg::KINV_Q28);
        y <= '0;
        z <= z_in;
      end else if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= y_in;
          y <= -x_in;
          z <= ZW'(oms_pkg::HALFPI_Q16);
        end else begin
          x <= -y_in;
          y <= x_in;
          z <= -ZW'(oms_pkg::HALFPI_Q16);
        end
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      n <= n + NW'(1);
    end
  end

  always_comb begin
    dx   = y >>> n;
    dy   = x >>> n;
    at   = oms_pkg::atan_q16(5'(n));
    plus = (mode == oms_pkg::CM_VECTOR) ? !y[CW-1] : z[ZW-1];
    if (plus) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = z;

endmodule

[rtl/oms_isqrt.sv]
// oms_isqrt: bit-serial integer square root, one result bit per cycle
// depends on oms_pkg (widths)

module oms_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [oms_pkg::SQ_W-1:0]      n_in,
  output logic                          done,
  output logic [oms_pkg::ROOT_W-1:0]    root
);

  localparam int SQ_W = oms_pkg::SQ_W;

  logic [SQ_W-1:0]           rem, res, bitv;
  logic [SQ_W:0]             trial;
  logic [oms_pkg::ISQ_CW-1:0] cnt;
  logic                      busy;

  assign trial = {1'b0, res} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == oms_pkg::ISQ_CW'(oms_pkg::ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= n_in;
      res  <= '0;
      bitv <= oms_pkg::SQ_ONE;
      cnt  <= '0;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + oms_pkg::ISQ_CW'(1);
    end
  end

  assign root = res[oms_pkg::ROOT_W-1:0];

endmodule

[rtl/orientation_median_smoother.sv]
// orientation_median_smoother: quaternion to euler angles, median-of-window smoothing,
// quaternion rebuild; uses oms_pkg, oms_cordic and oms_isqrt
//
//   channel  handshake               payload
//   in       in_valid / in_ready     quat_i, quat_j, quat_k, quat_real (Q2.14)
//   out      out_valid / out_ready   orient_x/y/z/w (Q2.14), compass_yaw (Q3.13)
//
// the time one beat takes is set by six passes through the shared cordic, the
// 29-step square root and one shared 33x33 multiplier; the median scan is skipped
// until the window is full
// in_ready is high only in idle; a finished beat sits in the output register while
// the next input beat is taken, and the sequencer holds before its write until it is free
// synchronous reset clears the sequencer, the fill count and out_valid

module orientation_median_smoother #(
  parameter int WINDOW       = oms_pkg::WINDOW_DEF,
  parameter int CORDIC_STEPS = oms_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] quat_i,
  input  logic signed [15:0] quat_j,
  input  logic signed [15:0] quat_k,
  input  logic signed [15:0] quat_real,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] orient_x,
  output logic signed [15:0] orient_y,
  output logic signed [15:0] orient_z,
  output logic signed [15:0] orient_w,
  output logic signed [15:0] compass_yaw
);

  localparam int ACC_W  = oms_pkg::ACC_W;
  localparam int A_W    = oms_pkg::A_W;
  localparam int CW     = oms_pkg::CW;
  localparam int ZW     = oms_pkg::ZW;
  localparam int MW     = oms_pkg::MUL_W;
  localparam int TRIG_W = oms_pkg::TRIG_W;
  localparam int PAIR_W = oms_pkg::PAIR_W;
  localparam int OACC_W = oms_pkg::OACC_W;
  localparam int SQ_W   = oms_pkg::SQ_W;
  localparam int ROOT_W = oms_pkg::ROOT_W;
  localparam int STEP_W = oms_pkg::STEP_W;
  localparam int LO_W   = oms_pkg::LO_W;
  localparam int CIDX_W = $clog2(WINDOW);
  localparam int FC_W   = $clog2(WINDOW + 1);
  localparam int MIDX   = WINDOW / 2;

  oms_pkg::state_t       state, state_next;
  logic [STEP_W-1:0]     k, k_next;
  logic [1:0]            sel, sel_next;
  logic                  load_out;

  logic signed [15:0]    qi, qj, qk, qr;
  logic signed [ACC_W-1:0] rx, ry, yx, yy, pa;
  logic signed [ACC_W:0] a2;
  logic signed [A_W-1:0] a_sat;
  logic [ROOT_W-1:0]     root;

  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] mp;

  logic signed [15:0]    roll_win  [WINDOW];
  logic signed [15:0]    pitch_win [WINDOW];
  logic signed [16:0]    yaw_win   [WINDOW];
  logic [FC_W-1:0]       fill_count;
  logic                  full;
  logic signed [16:0]    med [3];
  logic signed [16:0]    wv  [WINDOW];
  logic signed [16:0]    cand;
  logic [FC_W-1:0]       lt_cnt, le_cnt;
  logic                  med_hit;

  logic                  vzero;
  logic signed [ZW:0]    zr;
  logic signed [15:0]    vec_ang;
  logic signed [15:0]    rot_ang;
  logic signed [16:0]    yaw_wrap;

  logic signed [TRIG_W-1:0] cosv [3];
  logic signed [TRIG_W-1:0] sinv [3];
  logic signed [PAIR_W-1:0] pair [4];
  logic signed [PAIR_W-1:0] pv;
  logic signed [OACC_W-1:0] oacc [4];
  logic signed [OACC_W-1:0] tval;
  logic [3:0]               op_m, acc_m;
  oms_pkg::term_t           op_term, acc_term;

  oms_pkg::cordic_ctl_t  c_ctl;
  logic signed [CW-1:0]  c_xin, c_yin, c_xo, c_yo;
  logic signed [ZW-1:0]  c_zin, c_zo;
  logic                  c_done;

  logic                  isq_start, isq_done;
  logic [SQ_W-1:0]       isq_n;
  logic [ROOT_W-1:0]     isq_root;

  function automatic logic signed [15:0] qround(input logic signed [OACC_W-1:0] v);
    logic signed [OACC_W-1:0] r;
    r = (v + (OACC_W'(1) <<< (oms_pkg::OUT_SH - 1))) >>> oms_pkg::OUT_SH;
    if (r > OACC_W'(oms_pkg::QLIM)) begin
      return 16'(oms_pkg::QLIM);
    end else if (r < -OACC_W'(oms_pkg::QLIM)) begin
      return -16'(oms_pkg::QLIM);
    end
    return r[15:0];
  endfunction

  oms_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (c_ctl),
    .x_in  (c_xin),
    .y_in  (c_yin),
    .z_in  (c_zin),
    .done  (c_done),
    .x_out (c_xo),
    .y_out (c_yo),
    .z_out (c_zo)
  );

  oms_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (isq_start),
    .n_in  (isq_n),
    .done  (isq_done),
    .root  (isq_root)
  );

  assign full  = (fill_count == FC_W'(WINDOW));
  assign isq_n = oms_pkg::SQ_ONE - SQ_W'(mp);

  // pitch argument, clamped to one
  always_comb begin
    a2 = {pa, 1'b0};
    if (a2 > (ACC_W + 1)'(oms_pkg::ONE_Q28)) begin
      a_sat = A_W'(oms_pkg::ONE_Q28);
    end else if (a2 < -(ACC_W + 1)'(oms_pkg::ONE_Q28)) begin
      a_sat = -A_W'(oms_pkg::ONE_Q28);
    end else begin
      a_sat = a2[A_W-1:0];
    end
  end

  always_comb begin
    zr = {c_zo[ZW-1], c_zo} + (ZW + 1)'(4);
    zr = zr >>> 3;
    if (vzero) begin
      vec_ang = '0;
    end else if (zr > (ZW + 1)'(oms_pkg::PI_Q13)) begin
      vec_ang = 16'(oms_pkg::PI_Q13);
    end else if (zr < -(ZW + 1)'(oms_pkg::PI_Q13)) begin
      vec_ang = -16'(oms_pkg::PI_Q13);
    end else begin
      vec_ang = zr[15:0];
    end
  end

  always_comb begin
    if (med[2] > 17'(oms_pkg::PI_Q13)) begin
      yaw_wrap = med[2] - 17'(oms_pkg::TWOPI_Q13);
    end else if (med[2] < -17'(oms_pkg::PI_Q13)) begin
      yaw_wrap = med[2] + 17'(oms_pkg::TWOPI_Q13);
    end else begin
      yaw_wrap = med[2];
    end
  end

  always_comb begin
    unique case (sel)
      oms_pkg::ANG_ROLL: begin
        c_xin   = CW'(oms_pkg::ONE_Q28) - (CW'(rx) <<< 1);
        c_yin   = CW'(ry) <<< 1;
        rot_ang = med[1][15:0];
      end
      oms_pkg::ANG_PITCH: begin
        c_xin   = CW'({1'b0, root});
        c_yin   = CW'(a_sat);
        rot_ang = -med[0][15:0];
      end
      default: begin
        c_xin   = CW'(oms_pkg::ONE_Q28) - (CW'(yx) <<< 1);
        c_yin   = CW'(yy) <<< 1;
        rot_ang = yaw_wrap[15:0];
      end
    endcase
    c_zin = ZW'(rot_ang) <<< 2;
  end

  // rank of one window entry per cycle
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      unique case (sel)
        oms_pkg::ANG_ROLL:  wv[j] = 17'(roll_win[j]);
        oms_pkg::ANG_PITCH: wv[j] = 17'(pitch_win[j]);
        default:            wv[j] = yaw_win[j];
      endcase
    end
    cand   = wv[k[CIDX_W-1:0]];
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < WINDOW; j++) begin
      lt_cnt = lt_cnt + FC_W'(wv[j] < cand);
      le_cnt = le_cnt + FC_W'(wv[j] <= cand);
    end
    med_hit = (lt_cnt <= FC_W'(MIDX)) && (le_cnt > FC_W'(MIDX));
  end

  // shared multiplier operands
  always_comb begin
    ma      = '0;
    mb      = '0;
    op_m    = 4'(k - STEP_W'(4));
    acc_m   = 4'(k - STEP_W'(5));
    op_term = oms_pkg::term_of(op_m[3:1]);
    acc_term = oms_pkg::term_of(acc_m[3:1]);
    pv      = pair[op_term.pair];
    unique case (state)
      oms_pkg::ST_PROD: begin
        unique case (k)
          5'd0:    begin ma = MW'(qi); mb = MW'(qi); end
          5'd1:    begin ma = MW'(qj); mb = MW'(qj); end
          5'd2:    begin ma = MW'(qk); mb = MW'(qk); end
          5'd3:    begin ma = MW'(qr); mb = MW'(qi); end
          5'd4:    begin ma = MW'(qj); mb = MW'(qk); end
          5'd5:    begin ma = MW'(qr); mb = MW'(qj); end
          5'd6:    begin ma = MW'(qk); mb = MW'(qi); end
          5'd7:    begin ma = MW'(qr); mb = MW'(qk); end
          5'd8:    begin ma = MW'(qi); mb = MW'(qj); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      oms_pkg::ST_SQUARE: begin
        ma = MW'(a_sat);
        mb = MW'(a_sat);
      end
      oms_pkg::ST_QUAT: begin
        if (k < STEP_W'(4)) begin
          unique case (k[1:0])
            oms_pkg::PR_SRCP: begin ma = MW'(sinv[0]); mb = MW'(cosv[1]); end
            oms_pkg::PR_CRSP: begin ma = MW'(cosv[0]); mb = MW'(sinv[1]); end
            oms_pkg::PR_CRCP: begin ma = MW'(cosv[0]); mb = MW'(cosv[1]); end
            default:          begin ma = MW'(sinv[0]); mb = MW'(sinv[1]); end
          endcase
        end else if (k < oms_pkg::QUAT_LAST) begin
          ma = op_m[0] ? MW'({1'b0, pv[LO_W-1:0]}) : MW'(pv >>> LO_W);
          mb = op_term.use_sin ? MW'(sinv[2]) : MW'(cosv[2]);
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    tval = acc_m[0] ? OACC_W'(mp) : (OACC_W'(mp) <<< LO_W);
  end

  always_ff @(posedge clk) begin
    mp <= ma * mb;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oms_pkg::ST_IDLE;
      k     <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next   = state;
    k_next       = k;
    sel_next     = sel;
    in_ready     = 1'b0;
    c_ctl.start  = 1'b0;
    c_ctl.mode   = oms_pkg::CM_VECTOR;
    isq_start    = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      oms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = oms_pkg::ST_PROD;
          k_next     = '0;
        end
      end
      oms_pkg::ST_PROD: begin
        k_next = k + STEP_W'(1);
        if (k == oms_pkg::PROD_LAST) begin
          state_next = oms_pkg::ST_SQUARE;
          k_next     = '0;
        end
      end
      oms_pkg::ST_SQUARE: begin
        k_next = k + STEP_W'(1);
        if (k != '0) begin
          isq_start  = 1'b1;
          state_next = oms_pkg::ST_ROOT;
          k_next     = '0;
        end
      end
      oms_pkg::ST_ROOT: begin
        if (isq_done) begin
          state_next = oms_pkg::ST_VEC;
          sel_next   = oms_pkg::ANG_ROLL;
          k_next     = '0;
        end
      end
      oms_pkg::ST_VEC: begin
        if (k == '0) begin
          c_ctl.start = 1'b1;
          k_next      = STEP_W'(1);
        end else if (c_done) begin
          k_next = '0;
          if (sel == oms_pkg::ANG_YAW) begin
            sel_next   = oms_pkg::ANG_ROLL;
            state_next = full ? oms_pkg::ST_MED : oms_pkg::ST_ROT;
          end else begin
            sel_next = sel + 2'd1;
          end
        end
      end
      oms_pkg::ST_MED: begin
        k_next = k + STEP_W'(1);
        if (k == STEP_W'(WINDOW - 1)) begin
          k_next = '0;
          if (sel == oms_pkg::ANG_YAW) begin
            sel_next   = oms_pkg::ANG_ROLL;
            state_next = oms_pkg::ST_ROT;
          end else begin
            sel_next = sel + 2'd1;
          end
        end
      end
      oms_pkg::ST_ROT: begin
        c_ctl.mode = oms_pkg::CM_ROTATE;
        if (k == '0) begin
          c_ctl.start = 1'b1;
          k_next      = STEP_W'(1);
        end else if (c_done) begin
          k_next = '0;
          if (sel == oms_pkg::ANG_YAW) begin
            sel_next   = oms_pkg::ANG_ROLL;
            state_next = oms_pkg::ST_QUAT;
          end else begin
            sel_next = sel + 2'd1;
          end
        end
      end
      oms_pkg::ST_QUAT: begin
        k_next = k + STEP_W'(1);
        if (k == oms_pkg::QUAT_LAST) begin
          state_next = oms_pkg::ST_OUT;
          k_next     = '0;
        end
      end
      oms_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = oms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = oms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready && fill_count != FC_W'(WINDOW)) begin
        fill_count <= fill_count + FC_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      qi <= quat_i;
      qj <= quat_j;
      qk <= quat_k;
      qr <= quat_real;
      rx <= '0;
      ry <= '0;
      yx <= '0;
      yy <= '0;
      pa <= '0;
      for (int o = 0; o < 4; o++) begin
        oacc[o] <= '0;
      end
    end

    if (state == oms_pkg::ST_PROD && k != '0) begin
      unique case (k)
        5'd1:    rx <= rx + ACC_W'(mp);
        5'd2:    begin rx <= rx + ACC_W'(mp); yx <= yx + ACC_W'(mp); end
        5'd3:    yx <= yx + ACC_W'(mp);
        5'd4:    ry <= ry + ACC_W'(mp);
        5'd5:    ry <= ry + ACC_W'(mp);
        5'd6:    pa <= pa + ACC_W'(mp);
        5'd7:    pa <= pa - ACC_W'(mp);
        5'd8:    yy <= yy + ACC_W'(mp);
        default: yy <= yy + ACC_W'(mp);
      endcase
    end

    if (state == oms_pkg::ST_ROOT && isq_done) begin
      root <= isq_root;
    end

    if (state == oms_pkg::ST_VEC) begin
      if (k == '0) begin
        vzero <= (c_xin == '0) && (c_yin == '0);
      end else if (c_done) begin
        unique case (sel)
          oms_pkg::ANG_ROLL: begin
            for (int j = 0; j < WINDOW - 1; j++) begin
              roll_win[j] <= roll_win[j+1];
            end
            roll_win[WINDOW-1] <= vec_ang;
            med[0] <= 17'(vec_ang);
          end
          oms_pkg::ANG_PITCH: begin
            for (int j = 0; j < WINDOW - 1; j++) begin
              pitch_win[j] <= pitch_win[j+1];
            end
            pitch_win[WINDOW-1] <= vec_ang;
            med[1] <= 17'(vec_ang);
          end
          default: begin
            for (int j = 0; j < WINDOW - 1; j++) begin
              yaw_win[j] <= yaw_win[j+1];
            end
            yaw_win[WINDOW-1] <= 17'(vec_ang) + 17'(oms_pkg::HALFPI_Q13);
            med[2] <= 17'(vec_ang) + 17'(oms_pkg::HALFPI_Q13);
          end
        endcase
      end
    end

    if (state == oms_pkg::ST_MED && med_hit) begin
      med[sel] <= cand;
    end

    if (state == oms_pkg::ST_ROT && k != '0 && c_done) begin
      cosv[sel] <= TRIG_W'((c_xo + CW'(128)) >>> 8);
      sinv[sel] <= TRIG_W'((c_yo + CW'(128)) >>> 8);
    end

    if (state == oms_pkg::ST_QUAT) begin
      if (k != '0 && k < STEP_W'(5)) begin
        pair[2'(k - STEP_W'(1))] <= PAIR_W'(mp);
      end else if (k >= STEP_W'(5)) begin
        if (acc_term.neg) begin
          oacc[acc_term.dest] <= oacc[acc_term.dest] - tval;
        end else begin
          oacc[acc_term.dest] <= oacc[acc_term.dest] + tval;
        end
      end
    end

    if (load_out) begin
      orient_x    <= qround(oacc[0]);
      orient_y    <= qround(oacc[1]);
      orient_z    <= qround(oacc[2]);
      orient_w    <= qround(oacc[3]);
      compass_yaw <= yaw_wrap[15:0];
    end
  end

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == oms_pkg::ST_OUT)
    else $error("out beat raised outside the output step");

  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    c_done |-> (state == oms_pkg::ST_VEC || state == oms_pkg::ST_ROT) && k != '0)
    else $error("cordic finished while not awaited");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FC_W'(WINDOW))
    else $error("fill count past window");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted beat");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for orientation_median_smoother, directed and random samples
// against a fixed-point orientation predictor; depends on oms_pkg and the rtl

module tb_top;

  localparam int NWIN = 5;
  localparam int NSTEP = 14;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] x, y, z, w, yaw;
  } orient_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] quat_i = '0, quat_j = '0, quat_k = '0, quat_real = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] orient_x, orient_y, orient_z, orient_w, compass_yaw;

  orient_t expected_q[$];
  int err_cnt = 0;
  int stall_cnt = 0;
  bit calm = 1'b0;
  longint roll_hist[NWIN], pitch_hist[NWIN], yaw_hist[NWIN];
  int fill = 0;
  longint atan_tab[20] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                           64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  always #5 clk = ~clk;

  orientation_median_smoother i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .quat_i(quat_i), .quat_j(quat_j), .quat_k(quat_k), .quat_real(quat_real),
    .out_valid(out_valid), .out_ready(out_ready), .orient_x(orient_x),
    .orient_y(orient_y), .orient_z(orient_z), .orient_w(orient_w),
    .compass_yaw(compass_yaw)
  );

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint angle_of(longint x, longint y);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = oms_pkg::HALFPI_Q16;
      end else begin
        x = -y; y = t; z = -oms_pkg::HALFPI_Q16;
      end
    end
    for (int n = 0; n < NSTEP; n++) begin
      dx = shr(y, n);
      dy = shr(x, n);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[n];
      end else begin
        x -= dx; y += dy; z -= atan_tab[n];
      end
    end
    return clip(round_sh(z, 3), oms_pkg::PI_Q13);
  endfunction

  task automatic cos_sin(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = oms_pkg::KINV_Q28;
    y = 0;
    for (int n = 0; n < NSTEP; n++) begin
      dx = shr(y, n);
      dy = shr(x, n);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[n];
      end else begin
        x += dx; y -= dy; z += atan_tab[n];
      end
    end
    c = round_sh(x, 8);
    s = round_sh(y, 8);
  endtask

  function automatic longint median_shift(ref longint hist[NWIN], input longint v,
                                          input bit full);
    longint srt[NWIN];
    longint tmp;
    for (int i = 0; i < NWIN - 1; i++) hist[i] = hist[i + 1];
    hist[NWIN - 1] = v;
    if (!full) return v;
    srt = hist;
    for (int i = 0; i < NWIN; i++)
      for (int j = 0; j < NWIN - 1 - i; j++)
        if (srt[j] > srt[j + 1]) begin
          tmp = srt[j]; srt[j] = srt[j + 1]; srt[j + 1] = tmp;
        end
    return srt[NWIN / 2];
  endfunction

  function automatic logic signed [15:0] to_q14(longint a, longint b);
    return 16'(clip(round_sh(a + b, oms_pkg::OUT_SH), oms_pkg::QLIM));
  endfunction

  task automatic predict_orientation(input logic signed [15:0] vi, vj, vk, vr);
    longint qi, qj, qk, qr, roll, pitch, yaw, a, sq, nr, np;
    longint cr, sr, cp, sp, cy, sy;
    bit full;
    orient_t o;
    qi = vi; qj = vj; qk = vk; qr = vr;
    roll = angle_of(oms_pkg::ONE_Q28 - 2 * (qi * qi + qj * qj), 2 * (qr * qi + qj * qk));
    a = clip(2 * (qr * qj - qk * qi), oms_pkg::ONE_Q28);
    sq = int_sqrt(longint'(oms_pkg::ONE_Q28 * oms_pkg::ONE_Q28) - a * a);
    pitch = angle_of(sq, a);
    yaw = angle_of(oms_pkg::ONE_Q28 - 2 * (qj * qj + qk * qk), 2 * (qr * qk + qi * qj));
    if (fill < NWIN) fill++;
    full = (fill >= NWIN);
    roll = median_shift(roll_hist, roll, full);
    pitch = median_shift(pitch_hist, pitch, full);
    yaw = median_shift(yaw_hist, yaw + oms_pkg::HALFPI_Q13, full);
    if (yaw > oms_pkg::PI_Q13) yaw -= oms_pkg::TWOPI_Q13;
    if (yaw < -oms_pkg::PI_Q13) yaw += oms_pkg::TWOPI_Q13;
    nr = pitch;
    np = -roll;
    cos_sin(nr * 4, cr, sr);
    cos_sin(np * 4, cp, sp);
    cos_sin(yaw * 4, cy, sy);
    o.x = to_q14(sr * cp * cy, -(cr * sp * sy));
    o.y = to_q14(cr * sp * cy, sr * cp * sy);
    o.z = to_q14(cr * cp * sy, -(sr * sp * cy));
    o.w = to_q14(cr * cp * cy, sr * sp * sy);
    o.yaw = 16'(yaw);
    expected_q = {expected_q, o};
  endtask

  task automatic send_sample(input logic signed [15:0] vi, vj, vk, vr);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_i <= vi; quat_j <= vj; quat_k <= vk; quat_real <= vr;
    predict_orientation(vi, vj, vk, vr);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    return 16'($urandom_range(32768) - 16384);
  endfunction

  task automatic test_directed();
    send_sample(0, 0, 0, 0);
    send_sample(0, 0, 0, 16384);
    send_sample(16384, 0, 0, 0);
    send_sample(0, 16384, 0, 0);
    send_sample(0, 0, 16384, 0);
    send_sample(-16384, -16384, -16384, -16384);
    send_sample(16384, 16384, 16384, 16384);
    send_sample(11585, 0, 0, 11585);
    send_sample(0, 11585, 0, 11585);
    send_sample(0, 0, 11585, -11585);
    send_sample(0, 0, -16384, 1000);
    send_sample(-32768, 32767, -32768, 32767);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(-32768, -32768, -32768, -32768);
    send_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
  endtask

  task automatic test_random_unit();
    logic signed [15:0] vi, vj, vk, vr;
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 230);
      vi = rand_comp(); vj = rand_comp(); vk = rand_comp(); vr = rand_comp();
      send_sample(vi, vj, vk, vr);
    end
    calm = 1'b0;
  endtask

  task automatic test_random_raw();
    for (int n = 0; n < 140; n++)
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    orient_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (orient_x !== e.x) begin
          $error("orient_x exp %0d got %0d", e.x, orient_x); err_cnt++;
        end
        if (orient_y !== e.y) begin
          $error("orient_y exp %0d got %0d", e.y, orient_y); err_cnt++;
        end
        if (orient_z !== e.z) begin
          $error("orient_z exp %0d got %0d", e.z, orient_z); err_cnt++;
        end
        if (orient_w !== e.w) begin
          $error("orient_w exp %0d got %0d", e.w, orient_w); err_cnt++;
        end
        if (compass_yaw !== e.yaw) begin
          $error("compass_yaw exp %0d got %0d", e.yaw, compass_yaw); err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_unit();
    test_random_raw();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/oms_pkg.sv
rtl/oms_cordic.sv
rtl/oms_isqrt.sv
rtl/orientation_median_smoother.sv
sim/tb_top.sv
